>>> sv/hpt_pkg.sv
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 66;
  localparam int unsigned DIV_STEPS = 34;

  localparam logic signed [31:0] FIX_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] FIX_MIN = 32'sh8000_0000;

  typedef enum logic {
    CMD_VECTOR = 1'b0,
    CMD_POINT  = 1'b1
  } hpt_cmd_e;

  typedef struct packed {
    logic              command;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } hpt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic              divisor_replaced;
    logic              saturated;
  } hpt_out_t;

  typedef struct packed {
    logic [DIV_STEPS-1:0] quo;
    logic                 neg;
    logic                 ovf;
  } hpt_div_t;

  typedef struct packed {
    logic              flag;
    logic signed [31:0] value;
  } hpt_sat_t;

  function automatic hpt_sat_t div_to_fix(input hpt_div_t d);
    hpt_sat_t           r;
    logic [DIV_STEPS:0] mag;
    mag = ({1'b0, d.quo} + (DIV_STEPS+1)'(1)) >> 1;
    r.flag  = 1'b0;
    r.value = mag[31:0];
    if (d.ovf) begin
      r.flag  = 1'b1;
      r.value = d.neg ? FIX_MIN : FIX_MAX;
    end else if (!d.neg) begin
      if (mag > (DIV_STEPS+1)'(33'h0_7fff_ffff)) begin
        r.flag  = 1'b1;
        r.value = FIX_MAX;
      end
    end else begin
      if (mag > (DIV_STEPS+1)'(33'h0_8000_0000)) begin
        r.flag  = 1'b1;
        r.value = FIX_MIN;
      end else begin
        r.value = -mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

>>> sv/homogeneous_point_transform_unit.sv
`timescale 1ns / 1ps
// channel   | signals                                   | direction
// command   | start, busy, cmd_i                         | in/out
// result    | done_o, result_o                           | out
// config    | psel, penable, pwrite, paddr, pwdata,      | in/out
//           | prdata, pready                             |
// one transaction per clock; busy is always low
// pipeline: input, products, row sums, divisor prep, 35 divider
// stages (34 quotient bits, one per stage), output register
// reset clears the matrix to identity and all valid flags
// the receiver cannot stall; each result is valid on result_o while done_o is high for one cycle
module homogeneous_point_transform_unit #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned ZERO_EPSILON = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  hpt_pkg::hpt_in_t           cmd_i,
  output logic                       done_o,
  output hpt_pkg::hpt_out_t          result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpt_pkg::ADDR_W-1:0] paddr,
  input  logic [hpt_pkg::DATA_W-1:0] pwdata,
  output logic [hpt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hpt_pkg::*;

  localparam int unsigned SW    = ACC_W - FRAC_BITS;
  localparam int unsigned DLY   = DIV_STEPS + 1;
  localparam logic [DATA_W-1:0] ONE64 = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] ONE_W = SW'(1) << FRAC_BITS;

  typedef struct packed {
    logic              point;
    logic              replaced;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] sz;
    logic signed [SW-1:0] sw;
  } hpt_stage_t;

  logic [DATA_W-1:0] cfg_q [NUM_REGS];
  logic              cfg_we;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = cfg_q[paddr[ADDR_W-1:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= ONE64;
      cfg_q[1] <= '0;
      cfg_q[2] <= ONE64 << 32;
      cfg_q[3] <= '0;
      cfg_q[4] <= '0;
      cfg_q[5] <= ONE64;
      cfg_q[6] <= '0;
      cfg_q[7] <= ONE64 << 32;
    end else if (cfg_we) begin
      cfg_q[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  logic signed [31:0] coef [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = cfg_q[2*r + c/2][32*(c%2) +: 32];
      end
    end
  end

  // input register
  hpt_in_t in_q;
  logic    va_q, vb_q, vc_q;
  logic    pa_q, pb_q, pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= start & ~busy;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= cmd_i;
    pa_q <= cmd_i.command;
    pb_q <= pa_q;
    pc_q <= pb_q;
  end

  logic signed [31:0] vec [4];
  always_comb begin
    vec[0] = in_q.in_x;
    vec[1] = in_q.in_y;
    vec[2] = in_q.in_z;
    vec[3] = (in_q.command == CMD_POINT) ? 32'(ONE64) : in_q.in_w;
  end

  logic signed [SW-1:0] sum [4];
  for (genvar r = 0; r < 4; r++) begin : g_row
    hpt_row_lane #(.FRAC_BITS(FRAC_BITS)) u_row (
      .clk_i (clk_i),
      .coef_i(coef[r]),
      .vec_i (vec),
      .sum_o (sum[r])
    );
  end

  // divisor prep
  logic [SW-1:0] sw_mag;
  logic          rep_d;
  logic [DLY:0]  dly_v_q;
  hpt_stage_t    dly_q [DLY+1];

  always_comb begin
    sw_mag = sum[3][SW-1] ? SW'(-sum[3]) : SW'(sum[3]);
    rep_d  = (pc_q == CMD_POINT) && (sw_mag <= SW'(ZERO_EPSILON));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_v_q <= '0;
    end else begin
      dly_v_q <= {dly_v_q[DLY-1:0], vc_q};
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q[0].point    <= pc_q;
    dly_q[0].replaced <= rep_d;
    dly_q[0].sx       <= sum[0];
    dly_q[0].sy       <= sum[1];
    dly_q[0].sz       <= sum[2];
    dly_q[0].sw       <= rep_d ? ONE_W : sum[3];
    for (int i = 0; i < DLY; i++) begin
      dly_q[i+1].point    <= dly_q[i].point;
      dly_q[i+1].replaced <= dly_q[i].replaced;
      dly_q[i+1].sx       <= dly_q[i].sx;
      dly_q[i+1].sy       <= dly_q[i].sy;
      dly_q[i+1].sz       <= dly_q[i].sz;
      dly_q[i+1].sw       <= dly_q[i].sw;
    end
  end

  logic signed [SW-1:0] num [3];
  hpt_div_t             div [3];
  assign num[0] = dly_q[0].sx;
  assign num[1] = dly_q[0].sy;
  assign num[2] = dly_q[0].sz;

  for (genvar d = 0; d < 3; d++) begin : g_div
    hpt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i(clk_i),
      .num_i(num[d]),
      .den_i(dly_q[0].sw),
      .res_o(div[d])
    );
  end

  hpt_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dly_v_q[DLY]),
    .point_i   (dly_q[DLY].point),
    .replaced_i(dly_q[DLY].replaced),
    .sx_i      (dly_q[DLY].sx),
    .sy_i      (dly_q[DLY].sy),
    .sz_i      (dly_q[DLY].sz),
    .sw_i      (dly_q[DLY].sw),
    .div_i     (div),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

>>> sv/hpt_row_lane.sv
`timescale 1ns / 1ps
module hpt_row_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic signed [31:0]            coef_i [4],
  input  logic signed [31:0]            vec_i  [4],
  output logic signed [66-FRAC_BITS-1:0] sum_o
);
  import hpt_pkg::*;

  localparam int unsigned SW = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [ACC_W-1:0]  acc;
  logic signed [SW-1:0]     sum_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      prod_q[c] <= coef_i[c] * vec_i[c];
    end
  end

  always_comb begin
    acc = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2]) + ACC_W'(prod_q[3])
        + HALF;
  end

  always_ff @(posedge clk_i) begin
    sum_q <= SW'(acc >>> FRAC_BITS);
  end

  assign sum_o = sum_q;

endmodule

>>> sv/hpt_div_lane.sv
`timescale 1ns / 1ps
module hpt_div_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic signed [66-FRAC_BITS-1:0] num_i,
  input  logic signed [66-FRAC_BITS-1:0] den_i,
  output hpt_pkg::hpt_div_t             res_o
);
  import hpt_pkg::*;

  localparam int unsigned SW = ACC_W - FRAC_BITS;
  localparam int unsigned CW = SW + DIV_STEPS;
  localparam int unsigned K  = DIV_STEPS;

  logic [SW-1:0] un, ud;
  logic          neg, ovf;

  logic [CW-1:0] rem_q [K];
  logic [SW-1:0] ud_q  [K];
  logic [K-1:0]  quo_q [K+1];
  logic          neg_q [K+1];
  logic          ovf_q [K+1];

  always_comb begin
    neg = num_i[SW-1] ^ den_i[SW-1];
    un  = num_i[SW-1] ? SW'(-num_i) : SW'(num_i);
    ud  = den_i[SW-1] ? SW'(-den_i) : SW'(den_i);
    ovf = CW'(un) >= (CW'(ud) << (K - 1 - FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= CW'(un) << (FRAC_BITS + 1);
    ud_q[0]  <= ud;
    quo_q[0] <= '0;
    neg_q[0] <= neg;
    ovf_q[0] <= ovf;
  end

  for (genvar s = 0; s < K; s++) begin : g_step
    localparam int unsigned BIT = K - 1 - s;
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = CW'(ud_q[s]) << BIT;
    assign ge    = rem_q[s] >= trial;

    always_ff @(posedge clk_i) begin
      quo_q[s+1] <= {quo_q[s][K-2:0], ge};
      neg_q[s+1] <= neg_q[s];
      ovf_q[s+1] <= ovf_q[s];
    end

    if (s < K - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= ge ? rem_q[s] - trial : rem_q[s];
        ud_q[s+1]  <= ud_q[s];
      end
    end
  end

  assign res_o = '{quo: quo_q[K], neg: neg_q[K], ovf: ovf_q[K]};

endmodule

>>> sv/hpt_merge.sv
`timescale 1ns / 1ps
module hpt_merge #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          point_i,
  input  logic                          replaced_i,
  input  logic signed [66-FRAC_BITS-1:0] sx_i,
  input  logic signed [66-FRAC_BITS-1:0] sy_i,
  input  logic signed [66-FRAC_BITS-1:0] sz_i,
  input  logic signed [66-FRAC_BITS-1:0] sw_i,
  input  hpt_pkg::hpt_div_t             div_i [3],
  output logic                          done_o,
  output hpt_pkg::hpt_out_t             result_o
);
  import hpt_pkg::*;

  localparam int unsigned SW = ACC_W - FRAC_BITS;

  function automatic hpt_sat_t sat_wide(input logic signed [SW-1:0] v);
    hpt_sat_t r;
    r.flag  = 1'b0;
    r.value = v[31:0];
    if (v > SW'(FIX_MAX)) begin
      r.flag  = 1'b1;
      r.value = FIX_MAX;
    end else if (v < SW'(FIX_MIN)) begin
      r.flag  = 1'b1;
      r.value = FIX_MIN;
    end
    return r;
  endfunction

  hpt_sat_t cx, cy, cz, cw;
  hpt_out_t res_d, res_q;
  logic     done_q;

  always_comb begin
    cw = sat_wide(sw_i);
    if (point_i == CMD_POINT) begin
      cx = div_to_fix(div_i[0]);
      cy = div_to_fix(div_i[1]);
      cz = div_to_fix(div_i[2]);
    end else begin
      cx = sat_wide(sx_i);
      cy = sat_wide(sy_i);
      cz = sat_wide(sz_i);
    end
    res_d.out_x            = cx.value;
    res_d.out_y            = cy.value;
    res_d.out_z            = cz.value;
    res_d.out_w            = cw.value;
    res_d.divisor_replaced = replaced_i;
    res_d.saturated        = cx.flag | cy.flag | cz.flag | cw.flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
